>>> rtl/chd_pkg.sv
package chd_pkg;

  localparam int XY_W     = 28;
  localparam int Z_W      = 27;
  localparam int H_W      = 21;
  localparam int ATAN_LEN = 24;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  ang_t;

  typedef struct packed {
    xy_t  x;
    xy_t  y;
    ang_t z;
    logic zero;
  } cordic_t;

  typedef struct packed {
    logic [16:0] heading;
    logic [8:0]  cand;
    logic        hold_last;
  } post_t;

  localparam ang_t DEG90_Q16  = ang_t'(90 * 65536);
  localparam ang_t DEG360_Q16 = ang_t'(360 * 65536);

  localparam logic signed [16:0] DECL_MAX   = 17'sd46080;
  localparam logic signed [16:0] DECL_RESET = -17'sd1963;
  localparam logic [4:0]         DB_RESET   = 5'd3;

  localparam logic [1:0] REG_OFFSET_X    = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y    = 2'd1;
  localparam logic [1:0] REG_DECLINATION = 2'd2;
  localparam logic [1:0] REG_DEADBAND    = 2'd3;

  // floor(h*179/239) == (h*MAP_RECIP) >> MAP_SHIFT for h in 0..360
  localparam logic [19:0] MAP_RECIP = 20'd785336;
  localparam int          MAP_SHIFT = 20;
  localparam logic [8:0]  SEG_START = 9'd240;
  localparam logic [8:0]  SEG_BASE  = 9'd180;

  function automatic ang_t atan_deg_q16(input int unsigned i);
    ang_t r;
    case (i)
      0:       r = ang_t'(2949120);
      1:       r = ang_t'(1740967);
      2:       r = ang_t'(919879);
      3:       r = ang_t'(466945);
      4:       r = ang_t'(234379);
      5:       r = ang_t'(117304);
      6:       r = ang_t'(58666);
      7:       r = ang_t'(29335);
      8:       r = ang_t'(14668);
      9:       r = ang_t'(7334);
      10:      r = ang_t'(3667);
      11:      r = ang_t'(1833);
      12:      r = ang_t'(917);
      13:      r = ang_t'(458);
      14:      r = ang_t'(229);
      15:      r = ang_t'(115);
      16:      r = ang_t'(57);
      17:      r = ang_t'(29);
      18:      r = ang_t'(14);
      19:      r = ang_t'(7);
      20:      r = ang_t'(4);
      21:      r = ang_t'(2);
      22:      r = ang_t'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/chd_cordic_cell.sv
module chd_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  chd_pkg::cordic_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output chd_pkg::cordic_t out_data
);

  localparam chd_pkg::ang_t ATAN = chd_pkg::atan_deg_q16(IDX);

  logic             valid_r;
  chd_pkg::cordic_t data_r;
  chd_pkg::cordic_t data_nxt;
  chd_pkg::xy_t     xs;
  chd_pkg::xy_t     ys;

  assign xs = in_data.x >>> IDX;
  assign ys = in_data.y >>> IDX;

  always_comb begin
    data_nxt = in_data;
    if (in_data.y > 0) begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + ATAN;
    end else begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - ATAN;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/chd_post.sv
module chd_post #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  chd_pkg::cordic_t in_data,
  input  chd_pkg::ang_t    dec_q16,
  output logic             out_valid,
  input  logic             out_ready,
  output chd_pkg::post_t   out_data
);

  localparam int unsigned   SHIFT = 16 - FRAC_BITS;
  localparam chd_pkg::ang_t HALF  = chd_pkg::ang_t'(1 << (15 - FRAC_BITS));
  localparam chd_pkg::ang_t MAXH  = chd_pkg::ang_t'(360 << FRAC_BITS);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  // stage 1: declination and wrap
  chd_pkg::ang_t sum_w;
  chd_pkg::ang_t wrap_w;
  chd_pkg::ang_t h1_r;

  // stage 2: round to output format and clamp
  chd_pkg::ang_t           rnd_w;
  logic [chd_pkg::H_W-1:0] clamp_w;
  logic [16:0]             heading2_r;
  logic [8:0]              hd_r;

  // stage 3: correction map
  logic [28:0]    prod_w;
  logic [8:0]     lo_w;
  logic [8:0]     seg_w;
  logic [8:0]     hi_w;
  chd_pkg::post_t post_nxt;
  chd_pkg::post_t post_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    sum_w = (in_data.zero ? '0 : in_data.z) + dec_q16;
    if (sum_w < 0) begin
      wrap_w = sum_w + chd_pkg::DEG360_Q16;
    end else if (sum_w > chd_pkg::DEG360_Q16) begin
      wrap_w = sum_w - chd_pkg::DEG360_Q16;
    end else begin
      wrap_w = sum_w;
    end
  end

  always_comb begin
    rnd_w = (h1_r + HALF) >>> SHIFT;
    if (rnd_w < 0) begin
      clamp_w = '0;
    end else if (rnd_w > MAXH) begin
      clamp_w = chd_pkg::H_W'(MAXH);
    end else begin
      clamp_w = chd_pkg::H_W'(rnd_w);
    end
  end

  always_comb begin
    prod_w             = 29'(hd_r) * 29'(chd_pkg::MAP_RECIP);
    lo_w               = 9'(prod_w >> chd_pkg::MAP_SHIFT);
    seg_w              = hd_r - chd_pkg::SEG_START;
    hi_w               = 9'((10'(seg_w) * 10'd3) >> 1) + chd_pkg::SEG_BASE;
    post_nxt.heading   = heading2_r;
    post_nxt.hold_last = (hd_r == 9'd0);
    post_nxt.cand      = (hd_r >= chd_pkg::SEG_START) ? hi_w : lo_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      h1_r <= wrap_w;
    end
    if (rdy2 && v1_r) begin
      heading2_r <= 17'(clamp_w);
      hd_r       <= 9'(clamp_w >> FRAC_BITS);
    end
    if (rdy3 && v2_r) begin
      post_r <= post_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = post_r;

endmodule

>>> rtl/compass_heading_deadband_core.sv
// Magnetometer compass heading. One X/Y pair per item on in_tdata; the block takes
// a new item every cycle unless the output stalls, and returns one result per
// item, in order. The stages are an offset/quadrant stage, one CORDIC cell per
// iteration, three stages for declination/wrap, rounding and the correction map,
// and the output register, which also updates the mapped and smoothed history.
// Each stage stalls only when the stage after it is full. Configuration writes
// take effect at once and belong between runs of items.
module compass_heading_deadband_core #(
  parameter int unsigned CORDIC_STAGES   = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // raw_x[15:0], raw_y[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // heading_q8[16:0], mapped_heading[25:17],
                                  // smooth_heading[34:26], zero[39:35]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);

  logic signed [15:0] offset_x_r;
  logic signed [15:0] offset_y_r;
  logic signed [16:0] decl_r;
  logic [4:0]         deadband_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      decl_r     <= chd_pkg::DECL_RESET;
      deadband_r <= chd_pkg::DB_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        chd_pkg::REG_OFFSET_X:    offset_x_r <= cfg_wdata[15:0];
        chd_pkg::REG_OFFSET_Y:    offset_y_r <= cfg_wdata[15:0];
        chd_pkg::REG_DECLINATION: decl_r     <= cfg_wdata;
        chd_pkg::REG_DEADBAND:    deadband_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  logic signed [16:0] dec_sat;
  chd_pkg::ang_t      dec_q16;

  always_comb begin
    if (decl_r > chd_pkg::DECL_MAX) begin
      dec_sat = chd_pkg::DECL_MAX;
    end else if (decl_r < -chd_pkg::DECL_MAX) begin
      dec_sat = -chd_pkg::DECL_MAX;
    end else begin
      dec_sat = decl_r;
    end
    dec_q16 = chd_pkg::ang_t'(dec_sat) <<< 8;
  end

  // offset removal and quadrant fold
  logic signed [16:0] dx_w;
  logic signed [16:0] dy_w;
  chd_pkg::xy_t       xs_w;
  chd_pkg::xy_t       ys_w;
  chd_pkg::cordic_t   prep_nxt;

  chd_pkg::cordic_t chain_d   [CORDIC_STAGES+1];
  logic             chain_v   [CORDIC_STAGES+1];
  logic             chain_rdy [CORDIC_STAGES+1];

  always_comb begin
    dx_w          = {in_tdata[15], in_tdata[15:0]} - {offset_x_r[15], offset_x_r};
    dy_w          = {in_tdata[31], in_tdata[31:16]} - {offset_y_r[15], offset_y_r};
    xs_w          = chd_pkg::xy_t'(dx_w) <<< 8;
    ys_w          = chd_pkg::xy_t'(dy_w) <<< 8;
    prep_nxt.zero = (dx_w == '0) && (dy_w == '0);
    prep_nxt.x    = xs_w;
    prep_nxt.y    = ys_w;
    prep_nxt.z    = '0;
    if (xs_w < 0) begin
      if (ys_w >= 0) begin
        prep_nxt.x = ys_w;
        prep_nxt.y = -xs_w;
        prep_nxt.z = chd_pkg::DEG90_Q16;
      end else begin
        prep_nxt.x = -ys_w;
        prep_nxt.y = xs_w;
        prep_nxt.z = -chd_pkg::DEG90_Q16;
      end
    end
  end

  logic             prep_valid_r;
  chd_pkg::cordic_t prep_r;

  assign in_tready = !prep_valid_r || chain_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (in_tready) begin
      prep_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      prep_r <= prep_nxt;
    end
  end

  assign chain_v[0] = prep_valid_r;
  assign chain_d[0] = prep_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    chd_cordic_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[g]),
      .in_ready  (chain_rdy[g]),
      .in_data   (chain_d[g]),
      .out_valid (chain_v[g+1]),
      .out_ready (chain_rdy[g+1]),
      .out_data  (chain_d[g+1])
    );
  end

  logic           post_valid;
  logic           post_ready;
  chd_pkg::post_t post_data;

  chd_post #(
    .FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_v[CORDIC_STAGES]),
    .in_ready  (chain_rdy[CORDIC_STAGES]),
    .in_data   (chain_d[CORDIC_STAGES]),
    .dec_q16   (dec_q16),
    .out_valid (post_valid),
    .out_ready (post_ready),
    .out_data  (post_data)
  );

  // history and deadband, updated as each item enters the output register
  logic [8:0]  last_mapped_r;
  logic [8:0]  last_smooth_r;
  logic        out_valid_r;
  logic [16:0] out_heading_r;
  logic [8:0]  out_mapped_r;
  logic [8:0]  out_smooth_r;
  logic [8:0]  mapped_w;
  logic [8:0]  smooth_w;
  logic        in_band_w;
  logic        load_w;

  assign post_ready = !out_valid_r || out_tready;
  assign load_w     = post_valid && post_ready;

  always_comb begin
    mapped_w  = post_data.hold_last ? last_mapped_r : post_data.cand;
    in_band_w = (10'(mapped_w) < 10'(last_smooth_r) + 10'(deadband_r)) &&
                (10'(mapped_w) + 10'(deadband_r) > 10'(last_smooth_r));
    smooth_w  = in_band_w ? last_smooth_r : mapped_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      last_mapped_r <= '0;
      last_smooth_r <= '0;
    end else begin
      if (post_ready) out_valid_r <= post_valid;
      if (load_w) begin
        last_mapped_r <= mapped_w;
        last_smooth_r <= smooth_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_w) begin
      out_heading_r <= post_data.heading;
      out_mapped_r  <= mapped_w;
      out_smooth_r  <= smooth_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_smooth_r, out_mapped_r, out_heading_r};

  a_mapped_hist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_mapped_r == last_mapped_r)
    else $error("mapped history out of step with output");

  a_smooth_hist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_smooth_r == last_smooth_r)
    else $error("smooth history out of step with output");

  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_smooth_r != out_mapped_r) |->
      (10'(out_mapped_r) < 10'(out_smooth_r) + 10'(deadband_r)) &&
      (10'(out_mapped_r) + 10'(deadband_r) > 10'(out_smooth_r)))
    else $error("held heading outside deadband");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_mapped_r <= 9'd360) && (out_smooth_r <= 9'd360))
    else $error("heading above 360");

endmodule

>>> test/compass_heading_deadband_core_tb.sv
`timescale 1ns / 100ps

module compass_heading_deadband_core_tb;

  localparam int     STAGES   = 16;
  localparam int     FRAC     = 8;
  localparam longint FULL_Q16 = 360 * 65536;
  localparam real    PI       = 3.14159265358979;
  localparam int     PHASES   = 8;
  localparam int     PER_PHASE = 228;

  typedef struct packed {
    logic [16:0] heading;
    logic [8:0]  mapped;
    logic [8:0]  smooth;
  } fix_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  addr;
    logic [16:0] wdata;
    logic [15:0] rx;
    logic [15:0] ry;
    logic        pinned;
    fix_t        want;
  } step_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = chd_pkg::REG_OFFSET_X;
  logic [16:0] cfg_wdata  = '0;

  // shadow configuration and history
  logic signed [15:0] off_x    = '0;
  logic signed [15:0] off_y    = '0;
  logic signed [16:0] decl_q8  = -17'sd1963;
  logic [4:0]         deadband = 5'd3;
  int                 hist_mapped = 0;
  int                 hist_smooth = 0;

  longint arctan_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };
  int corner [0:4] = '{-32768, -1, 0, 1, 32767};

  fix_t  heading_due [$];
  int    mismatches = 0;
  int    idle_pct   = 20;
  int    stall_left = 0;
  logic  pinned     = 1'b0;
  fix_t  pinned_want = '0;
  step_t plan [$];

  compass_heading_deadband_core #(
    .CORDIC_STAGES  (STAGES),
    .ANGLE_FRAC_BITS(FRAC)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // atan2(y, x) in degrees Q16, vectoring mode
  function automatic longint cordic_deg_q16(input longint x0, input longint y0);
    longint x, y, z, t, xs, ys;
    if (x0 == 0 && y0 == 0) return 0;
    x = x0 * 256;
    y = y0 * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < STAGES && i < chd_pkg::ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + arctan_q16[i];
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_q16[i];
      end
    end
    return z;
  endfunction

  function automatic fix_t predict_heading(input logic signed [15:0] rx,
                                           input logic signed [15:0] ry);
    longint dx, dy, dec, h, hd;
    int     mapped, s, db;
    fix_t   r;
    dx  = longint'(rx) - longint'(off_x);
    dy  = longint'(ry) - longint'(off_y);
    dec = longint'(decl_q8);
    if (dec > 46080) dec = 46080;
    if (dec < -46080) dec = -46080;
    h = cordic_deg_q16(dx, dy) + dec * 256;
    if (h < 0) h = h + FULL_Q16;
    if (h > FULL_Q16) h = h - FULL_Q16;
    h = (h + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC);
    if (h < 0) h = 0;
    if (h > (longint'(360) << FRAC)) h = longint'(360) << FRAC;
    hd = h >>> FRAC;
    if (hd >= 1 && hd <= 239) mapped = int'(hd * 179 / 239);
    else if (hd >= 240) mapped = int'((hd - 240) * 180 / 120 + 180);
    else mapped = hist_mapped;
    db = int'(deadband);
    s  = mapped;
    if (s < hist_smooth + db && s > hist_smooth - db) s = hist_smooth;
    hist_mapped = mapped;
    hist_smooth = s;
    r.heading = h[16:0];
    r.mapped  = mapped[8:0];
    r.smooth  = s[8:0];
    return r;
  endfunction

  function automatic logic [15:0] sat16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic step_t mk(input logic is_cfg, input logic [1:0] addr,
                               input logic [16:0] wdata, input logic [15:0] rx,
                               input logic [15:0] ry, input logic pin,
                               input fix_t want);
    step_t r;
    r.is_cfg = is_cfg; r.addr = addr; r.wdata = wdata;
    r.rx = rx; r.ry = ry; r.pinned = pin; r.want = want;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic send_pair(input logic [15:0] rx, input logic [15:0] ry,
                           input logic pin, input fix_t want);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid   <= 1'b1;
    in_tdata    <= {ry, rx};
    pinned      = pin;
    pinned_want = want;
    do @(posedge clk); while (!in_tready);
  endtask

  // wait until every result is back and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (heading_due.size() != 0) @(posedge clk);
    repeat (STAGES + 6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [16:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      chd_pkg::REG_OFFSET_X:    off_x    = data[15:0];
      chd_pkg::REG_OFFSET_Y:    off_y    = data[15:0];
      chd_pkg::REG_DECLINATION: decl_q8  = data;
      chd_pkg::REG_DEADBAND:    deadband = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin : take_item
      fix_t p;
      p = predict_heading(in_tdata[15:0], in_tdata[31:16]);
      heading_due.push_back(pinned ? pinned_want : p);
    end
    if (rst_n && out_tvalid && out_tready) begin : take_result
      fix_t w;
      if (heading_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        w = heading_due.pop_front();
        if (out_tdata[16:0] != w.heading || out_tdata[25:17] != w.mapped ||
            out_tdata[34:26] != w.smooth || out_tdata[39:35] != 5'd0)
          note_mismatch($sformatf(
            "heading %0d/%0d mapped %0d/%0d smooth %0d/%0d pad %0d (exp/got)",
            w.heading, out_tdata[16:0], w.mapped, out_tdata[25:17],
            w.smooth, out_tdata[34:26], out_tdata[39:35]));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[compass_heading_deadband_core] ERROR");
    $finish;
  end

  initial begin
    step_t       row;
    int          n, k, run;
    real         ang, mag;
    logic [15:0] rx, ry;
    logic [16:0] ox, oy, dec;
    logic [4:0]  db;

    // zero vector after reset: -1963 wraps to 352.3 deg, maps to 348
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h0000, 16'h0000, 1,
                      {17'd90197, 9'd348, 9'd348}));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h0000, 16'h0000, 1,
                      {17'd90197, 9'd348, 9'd348}));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h7fff, 16'h0000, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h8000, 16'h0000, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h0000, 16'h7fff, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h0000, 16'h8000, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h8000, 16'h8000, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h7fff, 16'h7fff, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h8000, 16'h7fff, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h0001, 16'h0000, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'hffff, 16'h0000, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_DECLINATION, 17'h00000, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h0000, 16'h0000, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h0000, 16'hffff, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_OFFSET_X, 17'h07fff, 0, 0, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_OFFSET_Y, 17'h18000, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h7fff, 16'h8000, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h8000, 16'h7fff, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_OFFSET_X, 17'h08000, 0, 0, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_OFFSET_Y, 17'h07fff, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'h7fff, 16'h8000, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_OFFSET_X, 17'h00000, 0, 0, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_OFFSET_Y, 17'h00000, 0, 0, 0, '0));
    // declination beyond +-180 deg saturates
    plan.push_back(mk(1, chd_pkg::REG_DECLINATION, 17'h10000, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'd100, 16'd0, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_DECLINATION, 17'h0ffff, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'd100, 16'd0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, -16'sd100, 16'd1, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_DEADBAND, 17'd0, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'd100, 16'd5, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'd100, 16'd5, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_DEADBAND, 17'd31, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'd100, 16'd10, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, 16'd100, 16'd20, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_DECLINATION, 17'd46080, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, -16'sd100, 16'd0, 0, '0));
    plan.push_back(mk(1, chd_pkg::REG_DECLINATION, 17'h14c00, 0, 0, 0, '0));
    plan.push_back(mk(0, chd_pkg::REG_OFFSET_X, 0, -16'sd100, 16'd0, 0, '0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.addr, row.wdata);
      end else begin
        send_pair(row.rx, row.ry, row.pinned, row.want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      ox  = {1'($urandom_range(0, 1)), 16'($urandom)};
      oy  = {1'($urandom_range(0, 1)), 16'($urandom)};
      dec = 17'($urandom_range(0, 131071));
      db  = 5'($urandom_range(0, 31));
      case (phase)
        0: begin ox = 0; oy = 0; dec = 0; db = 0; end
        1: begin ox = 17'h08000; oy = 17'h07fff; dec = 17'd46080; db = 31; end
        2: dec = 17'h14c00;
        3: begin
          ox = {1'b0, sat16(int'($urandom_range(0, 400)) - 200)};
          oy = {1'b0, sat16(int'($urandom_range(0, 400)) - 200)};
          dec = 17'h0ffff; db = 3;
        end
        4: begin ox = 17'h07fff; oy = 17'h08000; dec = 17'h10000; end
        default: ;
      endcase
      settle();
      idle_pct = (phase == PHASES - 1) ? 0 : 10 * ((phase % 4) + 1);
      write_reg(chd_pkg::REG_OFFSET_X, ox);
      write_reg(chd_pkg::REG_OFFSET_Y, oy);
      write_reg(chd_pkg::REG_DECLINATION, dec);
      write_reg(chd_pkg::REG_DEADBAND, {12'd0, db});

      n = 0;
      while (n < PER_PHASE) begin
        k = $urandom_range(0, 99);
        if (k < 60) begin
          // slowly turning field around the hard-iron center
          run = $urandom_range(10, 40);
          ang = real'($urandom_range(0, 359));
          mag = $urandom_range(0, 1) ? real'($urandom_range(1, 30000))
                                     : real'($urandom_range(1, 40));
          repeat (run) begin
            ang = ang + real'(int'($urandom_range(0, 600)) - 300) / 100.0;
            rx  = sat16(int'(off_x) + $rtoi(mag * $cos(ang * PI / 180.0)));
            ry  = sat16(int'(off_y) + $rtoi(mag * $sin(ang * PI / 180.0)));
            send_pair(rx, ry, 1'b0, '0);
            n++;
          end
        end else if (k < 85) begin
          send_pair(16'($urandom), 16'($urandom), 1'b0, '0);
          n++;
        end else if (k < 95) begin
          rx = sat16(int'(off_x) + int'($urandom_range(0, 4)) - 2);
          ry = sat16(int'(off_y) + int'($urandom_range(0, 4)) - 2);
          send_pair(rx, ry, 1'b0, '0);
          n++;
        end else begin
          rx = 16'(corner[$urandom_range(0, 4)]);
          ry = 16'(corner[$urandom_range(0, 4)]);
          send_pair(rx, ry, 1'b0, '0);
          n++;
        end
      end
    end

    settle();
    repeat (STAGES + 10) @(posedge clk);
    if (mismatches == 0 && heading_due.size() == 0) begin
      $display("[compass_heading_deadband_core] OK");
    end else begin
      $display("[compass_heading_deadband_core] ERROR");
    end
    $finish;
  end

endmodule
